// ===== sv/lsra_pkg.sv =====
`timescale 1ns / 1ps

package lsra_pkg;

	// Width of the register count as written through the configuration port.
	localparam int NUM_REGS_W = 5;
	// Width of the register number in a result item.
	localparam int OUT_REG_W = 4;
	// Register count after reset.
	localparam logic [NUM_REGS_W-1:0] NUM_REGS_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPIRE,
		ST_ALLOC
	} lsra_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch the incoming interval
		logic refill;  // empty the active set and refill the free stack
		logic expire;  // retire the front active entry and push its register
		logic alloc;   // apply the allocation decision and load the result
	} lsra_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic expire_hit;  // front active entry ends before the latched begin
	} lsra_sts_t;

endpackage

// ===== sv/lsra_ctrl.sv =====
`timescale 1ns / 1ps

module lsra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              new_run,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	input  lsra_pkg::lsra_sts_t sts,
	output lsra_pkg::lsra_cmd_t cmd
);
	import lsra_pkg::*;

	lsra_state_t state_q;
	lsra_state_t state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					cmd.refill = new_run;
					state_nxt  = ST_EXPIRE;
				end
			end
			ST_EXPIRE: begin
				if (sts.expire_hit) begin
					cmd.expire = 1'b1;
				end else if (slot_free) begin
					cmd.alloc = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				if (slot_free) begin
					cmd.alloc = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// The result register is loaded by an allocation and emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.alloc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_alloc_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (!out_valid_q || m_tready))
		else $error("allocation overwrote a result that was not taken");
	a_alloc_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> m_tvalid)
		else $error("result not presented after allocation");
	a_expire_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.expire |-> (sts.expire_hit && state_q == ST_EXPIRE))
		else $error("expiry issued without an expired front entry");
`endif

endmodule

// ===== sv/lsra_dp.sv =====
`timescale 1ns / 1ps

module lsra_dp #(
	parameter int MAX_REGS  = 16,
	parameter int POS_WIDTH = 16,
	parameter int TAG_WIDTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsra_pkg::lsra_cmd_t                 cmd,
	output lsra_pkg::lsra_sts_t                 sts,
	input  logic [lsra_pkg::NUM_REGS_W-1:0]     num_regs,
	input  logic [TAG_WIDTH-1:0]                in_id,
	input  logic [POS_WIDTH-1:0]                in_begin,
	input  logic [POS_WIDTH-1:0]                in_end,
	output logic [TAG_WIDTH-1:0]                result_id,
	output logic [lsra_pkg::OUT_REG_W-1:0]      assigned_reg,
	output logic                                current_spilled,
	output logic                                victim_valid,
	output logic [TAG_WIDTH-1:0]                victim_id
);
	import lsra_pkg::*;

	localparam int REG_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int CNT_W = $clog2(MAX_REGS + 1);
	localparam logic [7:0] MAX8 = 8'(MAX_REGS);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGS);

	// Latched interval.
	logic [TAG_WIDTH-1:0] id_q;
	logic [POS_WIDTH-1:0] begin_q;
	logic [POS_WIDTH-1:0] end_q;

	// Active set, sorted by ascending end, front at index 0.
	logic [POS_WIDTH-1:0] act_end_q [MAX_REGS];
	logic [TAG_WIDTH-1:0] act_tag_q [MAX_REGS];
	logic [REG_W-1:0]     act_reg_q [MAX_REGS];
	logic [CNT_W-1:0]     act_cnt_q;

	// Free register stack, top at index 0.
	logic [REG_W-1:0]     stk_q [MAX_REGS];
	logic [CNT_W-1:0]     free_cnt_q;

	logic [7:0]           nr_w;
	logic [7:0]           eff8;
	logic [CNT_W-1:0]     eff_cnt;
	logic [CNT_W-1:0]     last_cnt;
	logic [REG_W-1:0]     last_idx;
	logic                 full;
	logic                 victim;
	logic                 take;
	logic [CNT_W-1:0]     base_cnt;
	logic [REG_W-1:0]     new_reg;
	logic [REG_W+OUT_REG_W-1:0] reg_ext;
	logic [MAX_REGS-1:0]  stay;
	logic [POS_WIDTH-1:0] ins_end [MAX_REGS];
	logic [TAG_WIDTH-1:0] ins_tag [MAX_REGS];
	logic [REG_W-1:0]     ins_reg [MAX_REGS];

	// A count of zero acts as one, a count above the array size as the size.
	assign nr_w = {{(8 - NUM_REGS_W){1'b0}}, num_regs};
	always_comb begin
		if (nr_w == 8'd0) begin
			eff8 = 8'd1;
		end else if (nr_w > MAX8) begin
			eff8 = MAX8;
		end else begin
			eff8 = nr_w;
		end
	end
	assign eff_cnt = eff8[CNT_W-1:0];

	assign last_cnt = act_cnt_q - CNT_W'(1);
	assign last_idx = last_cnt[REG_W-1:0];

	assign sts.expire_hit = (act_cnt_q != '0) && (act_end_q[0] < begin_q);

	// Allocation decision.
	assign full     = (act_cnt_q >= eff_cnt) || (free_cnt_q == '0);
	assign victim   = full && (act_cnt_q != '0) && (act_end_q[last_idx] > end_q);
	assign take     = !full || victim;
	assign base_cnt = victim ? last_cnt : act_cnt_q;
	assign new_reg  = victim ? act_reg_q[last_idx] : stk_q[0];
	assign reg_ext  = {{OUT_REG_W{1'b0}}, (take ? new_reg : REG_W'(0))};

	// Sorted insert: entries that end strictly earlier stay, the new entry
	// lands at the first place that does not, the rest move one place back.
	for (genvar k = 0; k < MAX_REGS; k++) begin : g_ins
		assign stay[k] = (CNT_W'(k) < base_cnt) && (act_end_q[k] < end_q);
		if (k == 0) begin : g_head
			always_comb begin
				if (stay[k]) begin
					ins_end[k] = act_end_q[k];
					ins_tag[k] = act_tag_q[k];
					ins_reg[k] = act_reg_q[k];
				end else begin
					ins_end[k] = end_q;
					ins_tag[k] = id_q;
					ins_reg[k] = new_reg;
				end
			end
		end else begin : g_body
			always_comb begin
				if (stay[k]) begin
					ins_end[k] = act_end_q[k];
					ins_tag[k] = act_tag_q[k];
					ins_reg[k] = act_reg_q[k];
				end else if (stay[k-1]) begin
					ins_end[k] = end_q;
					ins_tag[k] = id_q;
					ins_reg[k] = new_reg;
				end else begin
					ins_end[k] = act_end_q[k-1];
					ins_tag[k] = act_tag_q[k-1];
					ins_reg[k] = act_reg_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q    <= in_id;
			begin_q <= in_begin;
			end_q   <= in_end;
		end
		if (cmd.expire) begin
			for (int k = 0; k < MAX_REGS - 1; k++) begin
				act_end_q[k] <= act_end_q[k+1];
				act_tag_q[k] <= act_tag_q[k+1];
				act_reg_q[k] <= act_reg_q[k+1];
			end
		end else if (cmd.alloc && take) begin
			for (int k = 0; k < MAX_REGS; k++) begin
				act_end_q[k] <= ins_end[k];
				act_tag_q[k] <= ins_tag[k];
				act_reg_q[k] <= ins_reg[k];
			end
		end
		if (cmd.alloc) begin
			result_id       <= id_q;
			assigned_reg    <= reg_ext[OUT_REG_W-1:0];
			current_spilled <= !take;
			victim_valid    <= victim;
			victim_id       <= victim ? act_tag_q[last_idx] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cnt_q  <= '0;
			free_cnt_q <= CNT_W'(NUM_REGS_RESET > MAX8[NUM_REGS_W-1:0] && MAX_REGS < 32
				? MAX_REGS : NUM_REGS_RESET);
			for (int k = 0; k < MAX_REGS; k++) begin
				stk_q[k] <= REG_W'(k);
			end
		end else if (cmd.refill) begin
			act_cnt_q  <= '0;
			free_cnt_q <= eff_cnt;
			for (int k = 0; k < MAX_REGS; k++) begin
				stk_q[k] <= REG_W'(k);
			end
		end else if (cmd.expire) begin
			act_cnt_q <= last_cnt;
			if (free_cnt_q < MAX_CNT) begin
				for (int k = 1; k < MAX_REGS; k++) begin
					stk_q[k] <= stk_q[k-1];
				end
				stk_q[0]   <= act_reg_q[0];
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
		end else if (cmd.alloc) begin
			if (take) begin
				act_cnt_q <= base_cnt + CNT_W'(1);
			end
			if (!full) begin
				for (int k = 0; k < MAX_REGS - 1; k++) begin
					stk_q[k] <= stk_q[k+1];
				end
				free_cnt_q <= free_cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(act_cnt_q <= MAX_CNT) && (free_cnt_q <= MAX_CNT))
		else $error("active or free count beyond the register file");
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, act_cnt_q} + {1'b0, free_cnt_q}) <= {1'b0, MAX_CNT})
		else $error("more registers in use and free than exist");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(act_cnt_q >= CNT_W'(2) && MAX_REGS > 1) |-> (act_end_q[0] <= act_end_q[1]))
		else $error("active set out of order at its front");
`endif

endmodule

// ===== sv/linear_scan_register_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   tvalid / tready    tuser: new_run; tdata: id, begin, end
// m_        out  tvalid / tready    tuser: spill flags; tdata: id, reg, victim id
// cfg_      in   we only            wdata: num_regs
//
// An item is latched, then each active interval that it expires is retired
// (the active set and the free stack retire one entry per cycle), then the
// item is allocated and the result is loaded.
// Reset clears the active set and fills the free stack with registers
// 0..N-1, register 0 on top; num_regs comes up as 16.
// Input is taken only while the block is idle. A result that is not taken
// holds the block in its allocation step, so the next item is not taken in
// until the result register has room.

module linear_scan_register_allocator #(
	parameter int MAX_REGS  = 16,
	parameter int POS_WIDTH = 16,
	parameter int TAG_WIDTH = 10
) (
	input  logic clk,
	input  logic arst_n,
	// Input items.
	input  logic s_tvalid,
	output logic s_tready,
	// [TAG-1:0] interval_id, then interval_begin, then interval_end, zero pad.
	input  logic [((TAG_WIDTH + 2 * POS_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// [0] new_run
	input  logic s_tuser,
	// Result items.
	output logic m_tvalid,
	input  logic m_tready,
	// [TAG-1:0] result_id, then assigned_reg (4 bits), then victim_id, zero pad.
	output logic [((2 * TAG_WIDTH + lsra_pkg::OUT_REG_W + 7) / 8) * 8 - 1:0] m_tdata,
	// [0] current_spilled, [1] victim_valid
	output logic [1:0] m_tuser,
	// Register count.
	input  logic cfg_we,
	input  logic [lsra_pkg::NUM_REGS_W-1:0] cfg_wdata
);
	import lsra_pkg::*;

	localparam int OUT_W = ((2 * TAG_WIDTH + OUT_REG_W + 7) / 8) * 8;
	localparam int OUT_USED = 2 * TAG_WIDTH + OUT_REG_W;

	logic [NUM_REGS_W-1:0] num_regs_q;
	lsra_cmd_t             cmd;
	lsra_sts_t             sts;
	logic [TAG_WIDTH-1:0]  result_id;
	logic [OUT_REG_W-1:0]  assigned_reg;
	logic                  current_spilled;
	logic                  victim_valid;
	logic [TAG_WIDTH-1:0]  victim_id;

	// The count takes effect for the full test at once; the free stack only
	// follows it on the next run start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_regs_q <= NUM_REGS_RESET;
		end else if (cfg_we) begin
			num_regs_q <= cfg_wdata;
		end
	end

	lsra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.new_run  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsra_dp #(
		.MAX_REGS  (MAX_REGS),
		.POS_WIDTH (POS_WIDTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.num_regs        (num_regs_q),
		.in_id           (s_tdata[TAG_WIDTH-1:0]),
		.in_begin        (s_tdata[TAG_WIDTH+POS_WIDTH-1:TAG_WIDTH]),
		.in_end          (s_tdata[TAG_WIDTH+2*POS_WIDTH-1:TAG_WIDTH+POS_WIDTH]),
		.result_id       (result_id),
		.assigned_reg    (assigned_reg),
		.current_spilled (current_spilled),
		.victim_valid    (victim_valid),
		.victim_id       (victim_id)
	);

	// Result packing; the padding bits stay zero.
	assign m_tdata = OUT_W'({victim_id, assigned_reg, result_id});
	assign m_tuser = {victim_valid, current_spilled};

`ifndef SYNTHESIS
	a_spill_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("interval spilled and a victim reported for the same item");
	a_spill_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (assigned_reg == '0 && victim_id == '0))
		else $error("spilled interval carries a register or victim");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken before the first was allocated");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata >> OUT_USED) == '0))
		else $error("padding bits of a result are not zero");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the linear scan register allocator.
module tb_top;

	import lsra_pkg::*;

	localparam int MAX_REGS  = 16;
	localparam int POS_WIDTH = 16;
	localparam int TAG_WIDTH = 10;

	localparam int S_DATA_W = ((TAG_WIDTH + 2 * POS_WIDTH + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 * TAG_WIDTH + OUT_REG_W + 7) / 8) * 8;
	localparam int S_PAD_W  = S_DATA_W - TAG_WIDTH - 2 * POS_WIDTH;

	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 146;
	localparam int LONG_HOLD       = 400;
	localparam int DRAIN_CYCLES    = 4;
	localparam int TAIL_CYCLES     = 40;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int MAX_PRINTS      = 100;

	typedef logic [TAG_WIDTH-1:0] tag_t;
	typedef logic [POS_WIDTH-1:0] pos_t;

	// One result item as the block reports it.
	typedef struct packed {
		tag_t                 tag;
		logic [OUT_REG_W-1:0] phys_reg;
		logic                 spilled;
		logic                 victim_valid;
		tag_t                 victim_tag;
	} alloc_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// A row of the directed table: either a register count write or an interval.
	// Where typed is set, want holds the result read straight off the
	// allocation rule; otherwise the predictor supplies it.
	typedef struct packed {
		row_kind_t             kind;
		logic [NUM_REGS_W-1:0] reg_count;
		logic                  new_run;
		tag_t                  tag;
		pos_t                  start_pos;
		pos_t                  stop_pos;
		logic                  typed;
		alloc_result_t         want;
	} row_t;

	localparam int NUM_ROWS = 27;

	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// Reset state: 16 registers, register 0 on top of the free stack.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h3FF, 16'h0000, 16'hFFFF, 1'b1,
			'{10'h3FF, 4'd0, 1'b0, 1'b0, 10'h000}},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h001, 16'h0000, 16'h0000, 1'b1,
			'{10'h001, 4'd1, 1'b0, 1'b0, 10'h000}},
		// Expires the previous interval and reuses its register.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h002, 16'h0001, 16'h0005, 1'b0, '0},
		// Shrink the count without a new run: the set is full at once.
		'{ROW_CFG, 5'd1, 1'b0, 10'h000, 16'h0000, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h003, 16'h0002, 16'h0003, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b1, 10'h004, 16'h0000, 16'h000A, 1'b1,
			'{10'h004, 4'd0, 1'b0, 1'b0, 10'h000}},
		// Full set, new interval ends later: the interval itself spills.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h005, 16'h0002, 16'h0014, 1'b1,
			'{10'h005, 4'd0, 1'b1, 1'b0, 10'h000}},
		// Full set, active entry ends later: it is the victim.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h006, 16'h0003, 16'h0004, 1'b1,
			'{10'h006, 4'd0, 1'b0, 1'b1, 10'h004}},
		// A count of zero behaves as one register.
		'{ROW_CFG, 5'd0, 1'b0, 10'h000, 16'h0000, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b1, 10'h007, 16'h0064, 16'h0064, 1'b1,
			'{10'h007, 4'd0, 1'b0, 1'b0, 10'h000}},
		// Equal end points do not make a victim.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h008, 16'h0064, 16'h0064, 1'b1,
			'{10'h008, 4'd0, 1'b1, 1'b0, 10'h000}},
		// A count above the maximum is clipped to the maximum.
		'{ROW_CFG, 5'd31, 1'b0, 10'h000, 16'h0000, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b1, 10'h009, 16'hFFFF, 16'hFFFF, 1'b1,
			'{10'h009, 4'd0, 1'b0, 1'b0, 10'h000}},
		// Inverted, then out of order: no checks, plain compares.
		'{ROW_ITEM, 5'd0, 1'b0, 10'h00A, 16'hFFFF, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h00B, 16'h0000, 16'hFFFF, 1'b0, '0},
		// Run with two registers, then raise the count without a new run so
		// that the empty free stack is what makes the set full.
		'{ROW_CFG, 5'd2, 1'b0, 10'h000, 16'h0000, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b1, 10'h014, 16'h0000, 16'h0032, 1'b1,
			'{10'h014, 4'd0, 1'b0, 1'b0, 10'h000}},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h015, 16'h0000, 16'h0028, 1'b1,
			'{10'h015, 4'd1, 1'b0, 1'b0, 10'h000}},
		'{ROW_CFG, 5'd16, 1'b0, 10'h000, 16'h0000, 16'h0000, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h016, 16'h0001, 16'h003C, 1'b1,
			'{10'h016, 4'd0, 1'b1, 1'b0, 10'h000}},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h017, 16'h0002, 16'h002D, 1'b1,
			'{10'h017, 4'd0, 1'b0, 1'b1, 10'h014}},
		'{ROW_ITEM, 5'd0, 1'b1, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1,
			'{10'h3FF, 4'd0, 1'b0, 1'b0, 10'h000}},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h000, 16'hFFFF, 16'hFFFF, 1'b0, '0},
		// Fill a run with staggered intervals that expire several at once.
		'{ROW_ITEM, 5'd0, 1'b1, 10'h155, 16'h0010, 16'h0011, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h2AA, 16'h0010, 16'h0012, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h0F0, 16'h0011, 16'h00FF, 1'b0, '0},
		'{ROW_ITEM, 5'd0, 1'b0, 10'h30F, 16'h0100, 16'h0100, 1'b0, '0}
	};

	localparam logic [NUM_REGS_W-1:0] CORNER_COUNTS [4] = '{5'd1, 5'd16, 5'd0, 5'd31};

	logic clk;
	logic arst_n = 1'b0;

	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [NUM_REGS_W-1:0] cfg_wdata = '0;

	linear_scan_register_allocator #(
		.MAX_REGS (MAX_REGS),
		.POS_WIDTH(POS_WIDTH),
		.TAG_WIDTH(TAG_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Shadow copy of the allocator: the register count, the active set sorted
	// by end point, and the LIFO stack of free registers.
	logic [NUM_REGS_W-1:0] reg_count_q;
	int                    active_cnt;
	pos_t                  active_stop [MAX_REGS];
	tag_t                  active_tag  [MAX_REGS];
	logic [OUT_REG_W-1:0]  active_phys [MAX_REGS];
	logic [OUT_REG_W-1:0]  free_regs   [MAX_REGS];
	int                    free_cnt;

	// Results still owed by the block, oldest first.
	alloc_result_t pending_results [$];

	int err_count   = 0;
	int cycle_cnt   = 0;
	int burst_left  = 0;
	int hold_reqs   = 0;

	function automatic int usable_regs();
		int n;
		n = reg_count_q;
		if (n == 0) n = 1;
		if (n > MAX_REGS) n = MAX_REGS;
		return n;
	endfunction

	// Empty the active set and stack registers n-1 down to 0, so 0 is on top.
	function automatic void refill_regs();
		int n;
		n = usable_regs();
		active_cnt = 0;
		for (int k = 0; k < MAX_REGS; k++) begin
			active_stop[k] = '0;
			active_tag[k]  = '0;
			active_phys[k] = '0;
			free_regs[k]   = (k < n) ? OUT_REG_W'(n - 1 - k) : '0;
		end
		free_cnt = n;
	endfunction

	// New entries go ahead of any entry with the same end point.
	function automatic void insert_sorted(pos_t stop, tag_t tag, logic [OUT_REG_W-1:0] phys);
		int slot;
		if (active_cnt >= MAX_REGS) return;
		slot = 0;
		while (slot < active_cnt && active_stop[slot] < stop) slot++;
		for (int k = active_cnt; k > slot; k--) begin
			active_stop[k] = active_stop[k-1];
			active_tag[k]  = active_tag[k-1];
			active_phys[k] = active_phys[k-1];
		end
		active_stop[slot] = stop;
		active_tag[slot]  = tag;
		active_phys[slot] = phys;
		active_cnt++;
	endfunction

	// Handles one interval on the shadow state and returns the result it owes.
	function automatic alloc_result_t allocate_interval(logic new_run, tag_t tag,
			pos_t start_pos, pos_t stop_pos);
		alloc_result_t res;
		int            tail;
		res = '0;
		res.tag = tag;
		if (new_run) refill_regs();
		// Retire from the front every entry that ends before this interval starts.
		while (active_cnt > 0 && active_stop[0] < start_pos) begin
			if (free_cnt < MAX_REGS) begin
				free_regs[free_cnt] = active_phys[0];
				free_cnt++;
			end
			for (int k = 0; k < active_cnt - 1; k++) begin
				active_stop[k] = active_stop[k+1];
				active_tag[k]  = active_tag[k+1];
				active_phys[k] = active_phys[k+1];
			end
			active_cnt--;
		end
		if (active_cnt >= usable_regs() || free_cnt == 0) begin
			tail = active_cnt - 1;
			if (active_cnt > 0 && active_stop[tail] > stop_pos) begin
				res.phys_reg     = active_phys[tail];
				res.victim_valid = 1'b1;
				res.victim_tag   = active_tag[tail];
				active_cnt--;
				insert_sorted(stop_pos, tag, res.phys_reg);
			end else begin
				res.spilled = 1'b1;
			end
		end else begin
			free_cnt--;
			res.phys_reg = free_regs[free_cnt];
			insert_sorted(stop_pos, tag, res.phys_reg);
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
				got, want);
	endtask

	// Offers one interval and holds it until the block takes it. The valid
	// stays high on return so that back-to-back items follow without it dropping.
	task automatic send_item(logic new_run, tag_t tag, pos_t start_pos, pos_t stop_pos,
			logic typed, alloc_result_t want);
		alloc_result_t pred;
		s_tvalid <= 1'b1;
		s_tuser  <= new_run;
		s_tdata  <= {{S_PAD_W{1'b0}}, stop_pos, start_pos, tag};
		do @(posedge clk); while (!s_tready);
		pred = allocate_interval(new_run, tag, start_pos, stop_pos);
		pending_results.push_back(typed ? want : pred);
	endtask

	// Sender pacing: bursts of random length separated by random gaps, with
	// an occasional long burst that runs with no idling at all.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	// The count is only written with nothing in flight.
	task automatic write_reg_count(logic [NUM_REGS_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		reg_count_q = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: stall density changes from segment to segment, and on request
	// it holds off for a long stretch so that the block backs up its input.
	initial begin
		int seg_left;
		int stall_pct;
		int hold_left;
		int holds_done;
		seg_left   = 0;
		stall_pct  = 0;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 200);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 90;
					endcase
				end
				seg_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Every accepted result is matched against the oldest pending one. The
	// outputs are sampled at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tag          = m_tdata[TAG_WIDTH-1:0];
			got.phys_reg     = m_tdata[TAG_WIDTH +: OUT_REG_W];
			got.victim_tag   = m_tdata[TAG_WIDTH + OUT_REG_W +: TAG_WIDTH];
			got.spilled      = m_tuser[0];
			got.victim_valid = m_tuser[1];
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 16'(got.tag), '0);
			end else begin
				want = pending_results.pop_front();
				if (got.tag !== want.tag)
					report_mismatch("result_id", 16'(got.tag), 16'(want.tag));
				if (got.phys_reg !== want.phys_reg)
					report_mismatch("assigned_reg", 16'(got.phys_reg), 16'(want.phys_reg));
				if (got.spilled !== want.spilled)
					report_mismatch("current_spilled", 16'(got.spilled), 16'(want.spilled));
				if (got.victim_valid !== want.victim_valid)
					report_mismatch("victim_valid", 16'(got.victim_valid),
						16'(want.victim_valid));
				if (got.victim_tag !== want.victim_tag)
					report_mismatch("victim_id", 16'(got.victim_tag), 16'(want.victim_tag));
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("linear_scan_register_allocator verification failed");
		$finish;
	end

	initial begin
		row_t                  row;
		logic [NUM_REGS_W-1:0] count_val;
		logic                  run_start;
		logic                  item_run;
		int                    pos;
		int                    stop;
		int                    sent;
		int                    run_len;
		int                    max_step;
		int                    max_len;
		pos_t                  start_pos;
		pos_t                  stop_pos;

		reg_count_q = NUM_REGS_RESET;
		refill_regs();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.kind == ROW_CFG) begin
				write_reg_count(row.reg_count);
			end else begin
				pace();
				send_item(row.new_run, row.tag, row.start_pos, row.stop_pos, row.typed,
					row.want);
			end
		end

		// Random phases. Each uses one register count, the corner values
		// first. Most items are ordered runs of overlapping intervals; about
		// one in ten is an arbitrary interval thrown into the run.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			count_val = (ph < 4) ? CORNER_COUNTS[ph] : NUM_REGS_W'($urandom_range(0, 31));
			write_reg_count(count_val);
			if (ph == 1 || ph == 7) hold_reqs++;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				run_start = ($urandom_range(0, 9) != 0);
				pos       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 2000);
				run_len   = $urandom_range(1, 40);
				max_step  = $urandom_range(0, 6);
				max_len   = $urandom_range(0, 60);
				for (int i = 0; i < run_len && sent < ITEMS_PER_PHASE; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						start_pos = pos_t'($urandom);
						stop_pos  = pos_t'($urandom);
						item_run  = ($urandom_range(0, 19) == 0);
					end else begin
						pos = pos + $urandom_range(0, max_step);
						if (pos > 65535) pos = 65535;
						stop = pos + $urandom_range(0, max_len);
						if (stop > 65535) stop = 65535;
						start_pos = pos_t'(pos);
						stop_pos  = pos_t'(stop);
						item_run  = (i == 0) && run_start;
					end
					pace();
					send_item(item_run, tag_t'($urandom), start_pos, stop_pos, 1'b0, '0);
					sent++;
				end
			end
		end

		// Let the last results drain, then keep watching for strays before the verdict.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("linear_scan_register_allocator verification clean");
		end else begin
			$display("linear_scan_register_allocator verification failed");
		end
		$finish;
	end

endmodule
